### hdl/rtbs_pkg.sv
`default_nettype none

package rtbs_pkg;

	// field widths
	localparam int SIDE_W  = 9;
	localparam int POS_W   = 10;
	localparam int CH_W    = 8;
	localparam int COORD_W = 24;
	localparam int OUT_W   = 16;
	localparam int ROW_W   = 2 * SIDE_W;
	localparam int LIN_W   = ROW_W + 1;
	localparam int TEXEL_W = 4 * CH_W;

	// operation codes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	// configuration register indexes
	localparam logic REG_TEXTURE_WIDTH  = 1'b0;
	localparam logic REG_TEXTURE_HEIGHT = 1'b1;

	// neighbour select codes
	localparam logic [1:0] NB_00 = 2'd0;
	localparam logic [1:0] NB_10 = 2'd1;
	localparam logic [1:0] NB_01 = 2'd2;
	localparam logic [1:0] NB_11 = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOCATE,
		ST_ROWMUL,
		ST_ACC0,
		ST_ACC1,
		ST_ACC2,
		ST_ACC3,
		ST_WRITE,
		ST_WAIT,
		ST_HBLEND,
		ST_VBLEND
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       locate;
		logic       rowmul;
		logic       access;
		logic       write_texel;
		logic [1:0] sel;
		logic       hblend;
		logic       vblend;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       clr_last;
	} stat_t;

endpackage

`default_nettype wire

### hdl/rtbs_ctrl.sv
`default_nettype none

module rtbs_ctrl
	import rtbs_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire stat_t stat,
	output logic       busy,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				cmd.locate = 1'b1;
				state_d    = ST_ROWMUL;
			end
			ST_ROWMUL: begin
				cmd.rowmul = 1'b1;
				if (stat.op == OP_WRITE) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_ACC0;
				end
			end
			ST_ACC0: begin
				cmd.access = 1'b1;
				cmd.sel    = NB_00;
				if (stat.op == OP_SAMPLE) begin
					state_d = ST_ACC1;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_ACC1: begin
				cmd.access = 1'b1;
				cmd.sel    = NB_10;
				state_d    = ST_ACC2;
			end
			ST_ACC2: begin
				cmd.access = 1'b1;
				cmd.sel    = NB_01;
				state_d    = ST_ACC3;
			end
			ST_ACC3: begin
				cmd.access = 1'b1;
				cmd.sel    = NB_11;
				state_d    = ST_WAIT;
			end
			ST_WRITE: begin
				cmd.write_texel = 1'b1;
				state_d         = ST_VBLEND;
			end
			ST_WAIT: begin
				state_d = ST_HBLEND;
			end
			ST_HBLEND: begin
				cmd.hblend = 1'b1;
				state_d    = ST_VBLEND;
			end
			ST_VBLEND: begin
				cmd.vblend = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start_goes_locate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_LOCATE)
		else $error("accepted item did not enter locate");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !stat.clr_last) |=> state_q == ST_CLEAR)
		else $error("clear sweep left early");

	a_sample_four_fetches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC0 && stat.op == OP_SAMPLE) |=> state_q == ST_ACC1)
		else $error("sample skipped neighbour fetches");
`endif

endmodule

`default_nettype wire

### hdl/rtbs_datapath.sv
`default_nettype none

module rtbs_datapath
	import rtbs_pkg::*;
#(
	parameter int MAX_SIDE    = 256,
	parameter int STORE_DEPTH = 65536
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	input  wire                       cfg_we,
	input  wire                       cfg_index,
	input  wire  [SIDE_W-1:0]         cfg_wdata,
	input  wire  [1:0]                operation,
	input  wire  signed [POS_W-1:0]   texel_x,
	input  wire  signed [POS_W-1:0]   texel_y,
	input  wire  [CH_W-1:0]           red_in,
	input  wire  [CH_W-1:0]           green_in,
	input  wire  [CH_W-1:0]           blue_in,
	input  wire  [CH_W-1:0]           alpha_in,
	input  wire  signed [COORD_W-1:0] coord_u,
	input  wire  signed [COORD_W-1:0] coord_v,
	output logic                      done,
	output logic [OUT_W-1:0]          red_out,
	output logic [OUT_W-1:0]          green_out,
	output logic [OUT_W-1:0]          blue_out,
	output logic [OUT_W-1:0]          alpha_out
);

	localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int SIDE_CAP = (MAX_SIDE > 511) ? 511 : MAX_SIDE;
	localparam logic [SIDE_W-1:0] SideCapV = SIDE_W'(SIDE_CAP);
	localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(STORE_DEPTH - 1);

	// clamp a neighbour index to 0..side-1
	function automatic logic [SIDE_W-1:0] clamp_side(input logic signed [POS_W:0] v,
			input logic [SIDE_W-1:0] side);
		logic [SIDE_W-1:0] r;
		if (v[POS_W]) begin
			r = '0;
		end else if (v[POS_W-1:0] >= {1'b0, side}) begin
			r = side - 1'b1;
		end else begin
			r = v[SIDE_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [SIDE_W-1:0] side_w;
	logic [SIDE_W-1:0] side_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXTURE_WIDTH:  width_q  <= cfg_wdata;
				REG_TEXTURE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign side_w = (width_q > SideCapV) ? SideCapV : width_q;
	assign side_h = (height_q > SideCapV) ? SideCapV : height_q;

	// captured item
	logic [1:0]                op_q;
	logic signed [POS_W-1:0]   tx_q;
	logic signed [POS_W-1:0]   ty_q;
	logic [TEXEL_W-1:0]        wdata_q;
	logic [15:0]               fu_q;
	logic [15:0]               fv_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			tx_q    <= texel_x;
			ty_q    <= texel_y;
			wdata_q <= {alpha_in, blue_in, green_in, red_in};
			fu_q    <= coord_u[15:0];
			fv_q    <= coord_v[15:0];
		end
	end

	assign stat.op = op_q;

	// locate: p = f*side - 1/2 in Q.16, floor and weight straight from its bits
	logic [24:0]              prod_u;
	logic [24:0]              prod_v;
	logic signed [25:0]       p_u;
	logic signed [25:0]       p_v;
	logic signed [POS_W:0]    fl_u;
	logic signed [POS_W:0]    fl_v;
	logic [SIDE_W-1:0]        xa_d;
	logic [SIDE_W-1:0]        xb_d;
	logic [SIDE_W-1:0]        ya_d;
	logic [SIDE_W-1:0]        yb_d;
	logic [CH_W-1:0]          fx_d;
	logic [CH_W-1:0]          fy_d;
	logic                     ok_d;
	logic                     pos_ok;

	assign prod_u = 25'(fu_q) * 25'(side_w);
	assign prod_v = 25'(fv_q) * 25'(side_h);
	assign p_u    = $signed({1'b0, prod_u}) - 26'sd32768;
	assign p_v    = $signed({1'b0, prod_v}) - 26'sd32768;
	// arithmetic shift by 16, sign carried into the extra bit
	assign fl_u   = {p_u[25], p_u[25:16]};
	assign fl_v   = {p_v[25], p_v[25:16]};
	assign pos_ok = !tx_q[POS_W-1] && (tx_q[SIDE_W-1:0] < side_w)
		&& !ty_q[POS_W-1] && (ty_q[SIDE_W-1:0] < side_h);

	always_comb begin
		if (op_q == OP_SAMPLE) begin
			xa_d = clamp_side(fl_u, side_w);
			xb_d = clamp_side(fl_u + 11'sd1, side_w);
			ya_d = clamp_side(fl_v, side_h);
			yb_d = clamp_side(fl_v + 11'sd1, side_h);
			fx_d = p_u[15:8];
			fy_d = p_v[15:8];
			ok_d = (side_w != '0) && (side_h != '0);
		end else begin
			xa_d = tx_q[SIDE_W-1:0];
			xb_d = tx_q[SIDE_W-1:0];
			ya_d = ty_q[SIDE_W-1:0];
			yb_d = ty_q[SIDE_W-1:0];
			fx_d = '0;
			fy_d = '0;
			ok_d = pos_ok && (op_q == OP_WRITE || op_q == OP_READ);
		end
	end

	logic [SIDE_W-1:0] xa_q;
	logic [SIDE_W-1:0] xb_q;
	logic [SIDE_W-1:0] ya_q;
	logic [SIDE_W-1:0] yb_q;
	logic [CH_W-1:0]   fx_q;
	logic [CH_W-1:0]   fy_q;
	logic              ok_q;
	logic              res_en_q;

	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			xa_q     <= xa_d;
			xb_q     <= xb_d;
			ya_q     <= ya_d;
			yb_q     <= yb_d;
			fx_q     <= fx_d;
			fy_q     <= fy_d;
			ok_q     <= ok_d;
			res_en_q <= (op_q != OP_WRITE);
		end
	end

	// row bases
	logic [ROW_W-1:0] rowa_q;
	logic [ROW_W-1:0] rowb_q;

	always_ff @(posedge clk) begin
		if (cmd.rowmul) begin
			rowa_q <= ROW_W'(ya_q) * ROW_W'(side_w);
			rowb_q <= ROW_W'(yb_q) * ROW_W'(side_w);
		end
	end

	// texel store, single port
	logic [LIN_W-1:0]   lin;
	logic               inr;
	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;
	logic [TEXEL_W-1:0] mem_wdata;
	logic [TEXEL_W-1:0] rd_q;
	logic [TEXEL_W-1:0] mem [STORE_DEPTH];

	assign lin = LIN_W'(cmd.sel[1] ? rowb_q : rowa_q)
		+ LIN_W'(cmd.sel[0] ? xb_q : xa_q);
	assign inr       = 32'(lin) < 32'(STORE_DEPTH);
	assign mem_addr  = cmd.clear ? clr_q : ADDR_W'(lin);
	assign mem_we    = cmd.clear || (cmd.write_texel && ok_q && inr);
	assign mem_wdata = cmd.clear ? '0 : wdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (cmd.access) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clr_last = (clr_q == LastAddr);

	// gather fetched neighbours
	logic               acc_s1;
	logic [1:0]         sel_s1;
	logic               inr_s1;
	logic [TEXEL_W-1:0] texel_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.access;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cmd.sel;
		inr_s1 <= inr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				texel_q[i] <= '0;
			end
		end else if (acc_s1) begin
			texel_q[sel_s1] <= (inr_s1 && ok_q) ? rd_q : '0;
		end
	end

	// horizontal blend
	logic [SIDE_W-1:0] wx0;
	logic [SIDE_W-1:0] wy0;
	logic [OUT_W-1:0]  top_q [4];
	logic [OUT_W-1:0]  bot_q [4];

	assign wx0 = 9'd256 - SIDE_W'(fx_q);
	assign wy0 = 9'd256 - SIDE_W'(fy_q);

	always_ff @(posedge clk) begin
		if (cmd.hblend) begin
			for (int k = 0; k < 4; k++) begin
				top_q[k] <= OUT_W'(17'(texel_q[NB_00][8*k +: 8]) * 17'(wx0)
					+ 17'(texel_q[NB_10][8*k +: 8]) * 17'(fx_q));
				bot_q[k] <= OUT_W'(17'(texel_q[NB_01][8*k +: 8]) * 17'(wx0)
					+ 17'(texel_q[NB_11][8*k +: 8]) * 17'(fx_q));
			end
		end
	end

	// vertical blend and result register
	logic [23:0]      vsum [4];
	logic [OUT_W-1:0] out_q [4];
	logic             done_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vsum[k] = 24'(top_q[k]) * 24'(wy0) + 24'(bot_q[k]) * 24'(fy_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vblend) begin
			for (int k = 0; k < 4; k++) begin
				out_q[k] <= res_en_q ? vsum[k][23:8] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.vblend;
		end
	end

	assign done      = done_q;
	assign red_out   = out_q[0];
	assign green_out = out_q[1];
	assign blue_out  = out_q[2];
	assign alpha_out = out_q[3];

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_WRITE) |-> (red_out == '0 && green_out == '0
			&& blue_out == '0 && alpha_out == '0))
		else $error("write item gave a nonzero result");

	a_gather_before_blend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hblend |-> !acc_s1)
		else $error("blend started before last fetch was gathered");
`endif

endmodule

`default_nettype wire

### hdl/rgba_texture_bilinear_sampler_top.sv
// from accept to done strobe, a sample runs locate, row multiply, four fetches
// through the single-port texel store, wait and both blends; read and unknown op
// fetch once; write runs locate, row multiply, write, vertical blend; one item at
// a time. After reset, busy stays high while the store is swept to zero;
// configuration writes are taken during the sweep
// each result shows for exactly one cycle with done; the receiver cannot stall
`default_nettype none

module rgba_texture_bilinear_sampler_top
	import rtbs_pkg::*;
#(
	parameter int MAX_SIDE    = 256,
	parameter int STORE_DEPTH = 65536
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// item handshake
	input  wire                       start,
	output logic                      busy,
	input  wire  [1:0]                operation,
	input  wire  signed [POS_W-1:0]   texel_x,
	input  wire  signed [POS_W-1:0]   texel_y,
	input  wire  [CH_W-1:0]           red_in,
	input  wire  [CH_W-1:0]           green_in,
	input  wire  [CH_W-1:0]           blue_in,
	input  wire  [CH_W-1:0]           alpha_in,
	input  wire  signed [COORD_W-1:0] coord_u,
	input  wire  signed [COORD_W-1:0] coord_v,
	// result strobe and fields
	output logic                      done,
	output logic [OUT_W-1:0]          red_out,
	output logic [OUT_W-1:0]          green_out,
	output logic [OUT_W-1:0]          blue_out,
	output logic [OUT_W-1:0]          alpha_out,
	// register write port
	input  wire                       cfg_we,
	input  wire                       cfg_index,
	input  wire  [SIDE_W-1:0]         cfg_wdata
);

	// controller sequences locate, row multiply, fetches and the two blend steps
	cmd_t  cmd;
	stat_t stat;

	rtbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath holds the registers, the texel store and the blend arithmetic
	rtbs_datapath #(
		.MAX_SIDE    (MAX_SIDE),
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.operation (operation),
		.texel_x   (texel_x),
		.texel_y   (texel_y),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out)
	);

endmodule

`default_nettype wire
